// ===== src/tdeq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdeq_pkg: shared types and constants for the touch debounce event queue
// Holds the configuration register set, register indexes, rotation codes
// and the reset defaults used by the top level and the coordinate mapper.
// ----------------------------------------------------------------------------
package tdeq_pkg;

  // Default sizing handed to the top level parameters
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_COORD_BITS  = 10;

  // Field widths fixed by the register map
  localparam int CFG_BITS  = 11;
  localparam int ROT_BITS  = 2;
  localparam int REL_BITS  = 4;
  localparam int IDX_BITS  = 3;

  // Register indexes of the configuration port
  typedef enum logic [IDX_BITS-1:0] {
    REG_ROTATION      = 3'd0,
    REG_RELEASE_COUNT = 3'd1,
    REG_NATIVE_WIDTH  = 3'd2,
    REG_NATIVE_HEIGHT = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5
  } reg_idx_t;

  // Rotation modes from panel to screen
  typedef enum logic [ROT_BITS-1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_t;

  // Reset values of the registers
  localparam rot_t               RST_ROTATION      = ROT_90;
  localparam logic [REL_BITS-1:0] RST_RELEASE_COUNT = 4'd2;
  localparam logic [CFG_BITS-1:0] RST_NATIVE_WIDTH  = 11'd320;
  localparam logic [CFG_BITS-1:0] RST_NATIVE_HEIGHT = 11'd480;
  localparam logic [CFG_BITS-1:0] RST_SCREEN_WIDTH  = 11'd480;
  localparam logic [CFG_BITS-1:0] RST_SCREEN_HEIGHT = 11'd320;

  // Configuration register set
  typedef struct packed {
    rot_t                rotation;
    logic [REL_BITS-1:0] release_count;
    logic [CFG_BITS-1:0] native_width;
    logic [CFG_BITS-1:0] native_height;
    logic [CFG_BITS-1:0] screen_width;
    logic [CFG_BITS-1:0] screen_height;
  } cfg_t;

endpackage : tdeq_pkg
`default_nettype wire

// ===== src/tdeq_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdeq_map: panel to screen coordinate mapper
// Rotates a raw panel point by the configured mode and clamps the result
// to the screen, saturating at the largest coordinate code.
// ----------------------------------------------------------------------------
module tdeq_map #(
  parameter int COORD_BITS = tdeq_pkg::DEF_COORD_BITS
) (
  input  tdeq_pkg::cfg_t         cfg,
  input  logic [COORD_BITS-1:0]  raw_x,
  input  logic [COORD_BITS-1:0]  raw_y,
  output logic [COORD_BITS-1:0]  map_x,
  output logic [COORD_BITS-1:0]  map_y
);
  import tdeq_pkg::*;

  localparam int WB = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
  localparam int SW = WB + 2;
  localparam logic signed [SW-1:0] ONE_S  = SW'(1);
  localparam logic        [SW-1:0] MASK_E = SW'((64'd1 << COORD_BITS) - 64'd1);

  logic signed [SW-1:0] rx_s, ry_s, nw_m1, nh_m1, mx, my;
  logic        [SW-1:0] top_x, top_y;

  // Clamp bound: size minus one, zero for size zero, capped at the code range
  function automatic logic [SW-1:0] bound(input logic [CFG_BITS-1:0] size);
    logic [SW-1:0] t;
    t = (size == '0) ? '0 : (SW'(size) - SW'(1));
    if (t > MASK_E) t = MASK_E;
    return t;
  endfunction

  // Clamp a signed mapped value into [0, top]
  function automatic logic [COORD_BITS-1:0] limit(input logic signed [SW-1:0] v,
                                                  input logic [SW-1:0] top);
    logic [COORD_BITS-1:0] r;
    if (v < 0) r = '0;
    else if ($unsigned(v) > top) r = top[COORD_BITS-1:0];
    else r = v[COORD_BITS-1:0];
    return r;
  endfunction

  // Rotate in a signed intermediate wide enough for both operands
  always_comb begin
    rx_s  = $signed({{(SW-COORD_BITS){1'b0}}, raw_x});
    ry_s  = $signed({{(SW-COORD_BITS){1'b0}}, raw_y});
    nw_m1 = $signed({{(SW-CFG_BITS){1'b0}}, cfg.native_width}) - ONE_S;
    nh_m1 = $signed({{(SW-CFG_BITS){1'b0}}, cfg.native_height}) - ONE_S;
    case (cfg.rotation)
      ROT_90: begin
        mx = ry_s;
        my = nw_m1 - rx_s;
      end
      ROT_180: begin
        mx = nw_m1 - rx_s;
        my = nh_m1 - ry_s;
      end
      ROT_270: begin
        mx = nh_m1 - ry_s;
        my = rx_s;
      end
      default: begin
        mx = rx_s;
        my = ry_s;
      end
    endcase
    top_x = bound(cfg.screen_width);
    top_y = bound(cfg.screen_height);
    map_x = limit(mx, top_x);
    map_y = limit(my, top_y);
  end

endmodule : tdeq_map
`default_nettype wire

// ===== src/touch_debounce_event_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_debounce_event_queue: touch release debounce with event FIFO
// Debounces touch samples, queues press and release events and serves
// read requests from the oldest event or from the held sample.
// ----------------------------------------------------------------------------
// One item is accepted per clock unless a pending read is held up by a stalled
// result channel. A sample item (in_tuser = 0) is mapped, debounced and may push
// an event within its accept cycle and yields no result. A read item (in_tuser = 1)
// yields one result: the event queue is a memory with a registered read port, so
// the popped entry lands in a read register before the output register. Reads can
// follow each other in every cycle while the result channel does not stall. The
// queue keeps QUEUE_DEPTH events and drops the oldest when a new event arrives
// while it is full. The configuration port is always ready; write it only while idle.
module touch_debounce_event_queue #(
  parameter int QUEUE_DEPTH = tdeq_pkg::DEF_QUEUE_DEPTH,
  parameter int COORD_BITS  = tdeq_pkg::DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tdeq_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [tdeq_pkg::CFG_BITS-1:0]         cfg_data,
  // Input item channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tdata fields from bit 0: touch_valid, raw_x, raw_y, zero fill
  input  logic [((2*COORD_BITS+1+7)/8)*8-1:0]   in_tdata,
  // tuser fields from bit 0: action (0 sample, 1 read)
  input  logic                                  in_tuser,
  // Result channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // tdata fields from bit 0: point_x, point_y, is_pressed, events_left, zero fill
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0]   out_tdata
);
  import tdeq_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS+2+7)/8)*8;
  localparam int PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int EW    = 2*COORD_BITS + 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

  cfg_t cfg_r;

  logic [COORD_BITS-1:0] held_x_r, held_y_r;
  logic                  held_pressed_r;
  logic [REL_BITS-1:0]   miss_streak_r;
  logic [PW-1:0]         read_ptr_r, write_ptr_r;
  logic [FW-1:0]         fill_level_r;

  logic [COORD_BITS-1:0] held_x_nxt, held_y_nxt;
  logic                  held_pressed_nxt;
  logic [REL_BITS-1:0]   miss_streak_nxt;
  logic [PW-1:0]         read_ptr_nxt, write_ptr_nxt;
  logic [FW-1:0]         fill_level_nxt;

  logic [EW-1:0] event_mem [QUEUE_DEPTH];
  logic [EW-1:0] rd_q_r;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_mem_r;
  logic [EW-1:0]         s1_held_r;
  logic                  s1_more_r;
  logic                  out_valid_r;
  logic [OUT_W-1:0]      out_data_r;

  logic                  in_acc, sample_acc, read_acc, adv;
  logic                  touch_valid;
  logic [COORD_BITS-1:0] raw_x, raw_y, map_x, map_y;
  logic                  push, pop, full;
  logic [EW-1:0]         push_data, res_entry;

  // Unpack the input item
  assign touch_valid = in_tdata[0];
  assign raw_x       = in_tdata[COORD_BITS:1];
  assign raw_y       = in_tdata[2*COORD_BITS:COORD_BITS+1];

  // Handshakes
  assign cfg_ready  = 1'b1;
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || adv;
  assign in_acc     = in_tvalid && in_tready;
  assign sample_acc = in_acc && !in_tuser;
  assign read_acc   = in_acc && in_tuser;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rotation      <= RST_ROTATION;
      cfg_r.release_count <= RST_RELEASE_COUNT;
      cfg_r.native_width  <= RST_NATIVE_WIDTH;
      cfg_r.native_height <= RST_NATIVE_HEIGHT;
      cfg_r.screen_width  <= RST_SCREEN_WIDTH;
      cfg_r.screen_height <= RST_SCREEN_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_ROTATION:      cfg_r.rotation      <= rot_t'(cfg_data[ROT_BITS-1:0]);
        REG_RELEASE_COUNT: cfg_r.release_count <= cfg_data[REL_BITS-1:0];
        REG_NATIVE_WIDTH:  cfg_r.native_width  <= cfg_data;
        REG_NATIVE_HEIGHT: cfg_r.native_height <= cfg_data;
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  tdeq_map #(
    .COORD_BITS (COORD_BITS)
  ) u_map (
    .cfg   (cfg_r),
    .raw_x (raw_x),
    .raw_y (raw_y),
    .map_x (map_x),
    .map_y (map_y)
  );

  // Debounce the press state and update the queue pointers
  always_comb begin
    held_x_nxt       = held_x_r;
    held_y_nxt       = held_y_r;
    held_pressed_nxt = held_pressed_r;
    miss_streak_nxt  = miss_streak_r;
    full             = (fill_level_r == FILL_MAX);
    if (sample_acc) begin
      if (touch_valid) begin
        held_x_nxt       = map_x;
        held_y_nxt       = map_y;
        miss_streak_nxt  = '0;
        held_pressed_nxt = 1'b1;
      end else if (held_pressed_r && (miss_streak_r < cfg_r.release_count)) begin
        miss_streak_nxt  = miss_streak_r + 1'b1;
        held_pressed_nxt = 1'b1;
      end else begin
        held_pressed_nxt = 1'b0;
      end
    end
    push      = sample_acc && (held_pressed_nxt != held_pressed_r);
    pop       = read_acc && (fill_level_r != '0);
    push_data = {held_pressed_nxt, held_y_nxt, held_x_nxt};

    read_ptr_nxt   = read_ptr_r;
    write_ptr_nxt  = write_ptr_r;
    fill_level_nxt = fill_level_r;
    if (push) begin
      write_ptr_nxt = (write_ptr_r == PTR_LAST) ? '0 : write_ptr_r + 1'b1;
      if (full) read_ptr_nxt = (read_ptr_r == PTR_LAST) ? '0 : read_ptr_r + 1'b1;
      else fill_level_nxt = fill_level_r + 1'b1;
    end
    if (pop) begin
      read_ptr_nxt   = (read_ptr_r == PTR_LAST) ? '0 : read_ptr_r + 1'b1;
      fill_level_nxt = fill_level_r - 1'b1;
    end
    s1_valid_nxt = in_tready ? read_acc : s1_valid_r;
  end

  // Hold the debounce state and queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r       <= '0;
      held_y_r       <= '0;
      held_pressed_r <= 1'b0;
      miss_streak_r  <= '0;
      read_ptr_r     <= '0;
      write_ptr_r    <= '0;
      fill_level_r   <= '0;
      s1_valid_r     <= 1'b0;
    end else begin
      held_x_r       <= held_x_nxt;
      held_y_r       <= held_y_nxt;
      held_pressed_r <= held_pressed_nxt;
      miss_streak_r  <= miss_streak_nxt;
      read_ptr_r     <= read_ptr_nxt;
      write_ptr_r    <= write_ptr_nxt;
      fill_level_r   <= fill_level_nxt;
      s1_valid_r     <= s1_valid_nxt;
    end
  end

  // Event memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push) event_mem[write_ptr_r] <= push_data;
    if (read_acc) rd_q_r <= event_mem[read_ptr_r];
  end

  // Per read: queue nonempty flag, held sample for an empty queue, events left
  always_ff @(posedge clk) begin
    if (read_acc) begin
      s1_mem_r  <= (fill_level_r != '0);
      s1_held_r <= {held_pressed_r, held_y_r, held_x_r};
      s1_more_r <= (fill_level_nxt != '0);
    end
  end

  // Advance the result into the output register
  assign res_entry = s1_mem_r ? rd_q_r : s1_held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_data_r <= OUT_W'({s1_more_r, res_entry});
    end
  end

endmodule : touch_debounce_event_queue
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the touch debounce event queue
// Streams sample and read items into the block under changing register
// settings and random stalls on both channels. A behavioral tracker of the
// debounce state and the event FIFO predicts each read result not given by a
// directed row, and results are checked field by field, oldest expectation first.
// ----------------------------------------------------------------------------
module tb;
  import tdeq_pkg::*;

  localparam int QUEUE_DEPTH = DEF_QUEUE_DEPTH;
  localparam int COORD_MAX   = (1 << DEF_COORD_BITS) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE      = 8;
  localparam int NUM_PHASES  = 9;
  localparam int PHASE_ITEMS = 195;
  localparam int DIR_ROWS    = 24;

  // Item kinds carried on in_tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // One queued touch event
  typedef struct {
    logic [9:0] x;
    logic [9:0] y;
    logic       pressed;
  } touch_evt_t;

  // One read result, laid out as out_tdata from bit 0 up
  typedef struct packed {
    logic       more;
    logic       pressed;
    logic [9:0] y;
    logic [9:0] x;
  } point_t;

  // One directed stimulus row
  typedef struct {
    logic       act;
    logic       tv;
    logic [9:0] rx;
    logic [9:0] ry;
    bit         typed;
    point_t     want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [10:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // Tracker state
  cfg_t        model_cfg;
  logic [9:0]  held_x;
  logic [9:0]  held_y;
  logic        held_pressed;
  logic [3:0]  miss_streak;
  touch_evt_t  event_fifo[$];
  point_t      expected_points[$];

  int          errors;
  int          cycle_count;
  int          send_idle;
  int          recv_idle;

  touch_debounce_event_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Directed rows, run under the reset settings
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 10'd0,   10'd0}},
    '{ACT_SAMPLE, 1'b1, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b1, '{1'b0, 1'b1, 10'd319, 10'd0}},
    '{ACT_SAMPLE, 1'b1, 10'd1023,  10'd1023,  1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b1, '{1'b0, 1'b1, 10'd0,   10'd479}},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 10'd0,   10'd479}},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b1, '{1'b0, 1'b0, 10'd0,   10'd479}},
    '{ACT_SAMPLE, 1'b1, 10'h2aa,   10'h155,   1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'h3ff,   10'h3ff,   1'b0, '0},
    '{ACT_SAMPLE, 1'b1, 10'h155,   10'h2aa,   1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_SAMPLE, 1'b1, 10'h3ff,   10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b0, 10'd0,     10'd0,     1'b0, '0},
    '{ACT_READ,   1'b1, 10'h3ff,   10'h3ff,   1'b0, '0},
    '{ACT_SAMPLE, 1'b0, 10'h3ff,   10'h3ff,   1'b0, '0}
  };

  // Fixed register settings for phases one to six
  cfg_t fixed_cfgs [6] = '{
    '{ROT_NONE, 4'd0,  11'd1024, 11'd1024, 11'd1024, 11'd1024},
    '{ROT_90,   4'd15, 11'd1,    11'd1,    11'd1,    11'd1},
    '{ROT_180,  4'd3,  11'd640,  11'd480,  11'd800,  11'd600},
    '{ROT_270,  4'd0,  11'd320,  11'd480,  11'd480,  11'd320},
    '{ROT_180,  4'd15, 11'd1024, 11'd1024, 11'd1024, 11'd1024},
    '{ROT_270,  4'd1,  11'd100,  11'd1000, 11'd512,  11'd256}
  };

  // Clamp a mapped coordinate to the screen
  function automatic logic [9:0] fit_to_screen(int v, int size);
    int top;
    top = (size == 0) ? 0 : size - 1;
    if (top > COORD_MAX) top = COORD_MAX;
    if (v < 0) return 10'd0;
    if (v > top) return top[9:0];
    return v[9:0];
  endfunction

  // Pick a coordinate, leaning on the range ends
  function automatic logic [9:0] pick_coord();
    case ($urandom_range(0, 7))
      0:       return 10'd0;
      1:       return 10'(COORD_MAX);
      default: return 10'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  // Advance the tracker by one item; a read yields the predicted point
  task automatic track_touch(input logic act, input logic tv, input logic [9:0] rx,
                             input logic [9:0] ry, output bit has_pt, output point_t pt);
    int rxi, ryi, nw, nh, mx, my;
    logic next;
    touch_evt_t ev;
    has_pt = 1'b0;
    pt = '0;
    if (act == ACT_SAMPLE) begin
      rxi = rx;
      ryi = ry;
      nw = model_cfg.native_width;
      nh = model_cfg.native_height;
      if (tv) begin
        mx = rxi;
        my = ryi;
        case (model_cfg.rotation)
          ROT_90: begin
            mx = ryi;
            my = (nw - 1) - rxi;
          end
          ROT_180: begin
            mx = (nw - 1) - rxi;
            my = (nh - 1) - ryi;
          end
          ROT_270: begin
            mx = (nh - 1) - ryi;
            my = rxi;
          end
          default: ;
        endcase
        miss_streak = 4'd0;
        held_x = fit_to_screen(mx, model_cfg.screen_width);
        held_y = fit_to_screen(my, model_cfg.screen_height);
        next = 1'b1;
      end else if (held_pressed && miss_streak < model_cfg.release_count) begin
        miss_streak = miss_streak + 4'd1;
        next = 1'b1;
      end else begin
        next = 1'b0;
      end
      // Push on every change of the press state, dropping the oldest when full
      if (next != held_pressed) begin
        if (event_fifo.size() >= QUEUE_DEPTH) event_fifo.delete(0);
        ev.x = held_x;
        ev.y = held_y;
        ev.pressed = next;
        event_fifo.push_back(ev);
      end
      held_pressed = next;
    end else begin
      has_pt = 1'b1;
      if (event_fifo.size() > 0) begin
        ev = event_fifo.pop_front();
        pt.x = ev.x;
        pt.y = ev.y;
        pt.pressed = ev.pressed;
      end else begin
        pt.x = held_x;
        pt.y = held_y;
        pt.pressed = held_pressed;
      end
      pt.more = (event_fifo.size() > 0);
    end
  endtask

  // Drive one item from a falling edge and hold it until accepted
  task automatic send_item(input logic act, input logic tv, input logic [9:0] rx,
                           input logic [9:0] ry, input bit typed, input point_t want);
    bit has_pt;
    point_t pt;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, ry, rx, tv};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_touch(act, tv, rx, ry, has_pt, pt);
    if (has_pt) expected_points.push_back(typed ? want : pt);
    @(negedge clk);
  endtask

  // Write one register and mirror it in the tracker
  task automatic write_reg(input reg_idx_t idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROTATION:      model_cfg.rotation      = rot_t'(val[1:0]);
      REG_RELEASE_COUNT: model_cfg.release_count = val[3:0];
      REG_NATIVE_WIDTH:  model_cfg.native_width  = val;
      REG_NATIVE_HEIGHT: model_cfg.native_height = val;
      REG_SCREEN_WIDTH:  model_cfg.screen_width  = val;
      REG_SCREEN_HEIGHT: model_cfg.screen_height = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Hold the sender until every result is in, then let the pipeline settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_points.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL touch_debounce_event_queue");
      $finish;
    end
  end

  // Receiver stalls
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    point_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = point_t'(out_tdata[21:0]);
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_tdata);
      end else begin
        want = expected_points.pop_front();
        check_field("point_x", want.x, got.x);
        check_field("point_y", want.y, got.y);
        check_field("is_pressed", want.pressed, got.pressed);
        check_field("events_left", want.more, got.more);
      end
    end
  end

  // Stimulus
  initial begin
    int phase, n, read_pct;
    bit stroke_on;
    logic tv;
    errors = 0;
    cycle_count = 0;
    send_idle = 16;
    recv_idle = 69;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tuser = ACT_SAMPLE;
    in_tdata = '0;
    out_tready = 1'b0;
    stroke_on = 1'b0;
    model_cfg = '{RST_ROTATION, RST_RELEASE_COUNT, RST_NATIVE_WIDTH,
                  RST_NATIVE_HEIGHT, RST_SCREEN_WIDTH, RST_SCREEN_HEIGHT};
    held_x = '0;
    held_y = '0;
    held_pressed = 1'b0;
    miss_streak = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows
    for (n = 0; n < DIR_ROWS; n++) begin
      send_item(dir_rows[n].act, dir_rows[n].tv, dir_rows[n].rx, dir_rows[n].ry,
                dir_rows[n].typed, dir_rows[n].want);
    end
    wait_drained();

    // Random phases: first sender light and receiver heavy stalls, then swapped, then none
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          send_idle = 16;
          recv_idle = 69;
        end
        1: begin
          send_idle = 69;
          recv_idle = 16;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase >= 1 && phase <= 6) begin
        write_reg(REG_ROTATION,      11'(fixed_cfgs[phase-1].rotation));
        write_reg(REG_RELEASE_COUNT, 11'(fixed_cfgs[phase-1].release_count));
        write_reg(REG_NATIVE_WIDTH,  fixed_cfgs[phase-1].native_width);
        write_reg(REG_NATIVE_HEIGHT, fixed_cfgs[phase-1].native_height);
        write_reg(REG_SCREEN_WIDTH,  fixed_cfgs[phase-1].screen_width);
        write_reg(REG_SCREEN_HEIGHT, fixed_cfgs[phase-1].screen_height);
        cfg_valid <= 1'b0;
      end else if (phase > 6) begin
        write_reg(REG_ROTATION,      11'($urandom_range(0, 3)));
        write_reg(REG_RELEASE_COUNT, 11'($urandom_range(0, 15)));
        write_reg(REG_NATIVE_WIDTH,  11'($urandom_range(1, 1024)));
        write_reg(REG_NATIVE_HEIGHT, 11'($urandom_range(1, 1024)));
        write_reg(REG_SCREEN_WIDTH,  11'($urandom_range(1, 1024)));
        write_reg(REG_SCREEN_HEIGHT, 11'($urandom_range(1, 1024)));
        cfg_valid <= 1'b0;
      end
      // Few reads let the FIFO fill and overflow; many reads empty it
      read_pct = (phase % 2 == 0) ? 12 : 45;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_drained();
        if ($urandom_range(0, 99) < read_pct) begin
          send_item(ACT_READ, 1'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                    1'b0, '0);
        end else begin
          // Strokes: mostly valid while touching, mostly invalid between
          if ($urandom_range(0, 7) == 0) stroke_on = !stroke_on;
          tv = stroke_on ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
          send_item(ACT_SAMPLE, tv, pick_coord(), pick_coord(), 1'b0, '0);
        end
      end
      wait_drained();
    end

    if (expected_points.size() > 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_points.size());
    end
    if (errors == 0) begin
      $display("PASS touch_debounce_event_queue");
    end else begin
      $display("FAIL touch_debounce_event_queue");
    end
    $finish;
  end

endmodule
